### rtl/core/gtiw_pkg.sv
package gtiw_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int WYEAR_W  = 14;
   localparam int WNUM_W   = 6;
   localparam int WDAY_W   = 3;
   localparam int DCOUNT_W = 22;

   localparam int STAGES = 12;
   localparam int NCAND  = 4;

   localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;
   localparam logic [8:0]         DAY_OFFSET  = 9'd62;

   // reciprocals: floor(x / k) = (x * RECIP) >> shift
   localparam logic [14:0] RECIP_100  = 15'd20972;  // shift 21
   localparam logic [14:0] RECIP_400  = 15'd20972;  // shift 23
   localparam logic [15:0] RECIP_YEAR = 16'd45934;  // 400/146097, shift 24
   localparam logic [9:0]  RECIP_100B = 10'd656;    // shift 16
   localparam logic [11:0] RECIP_28   = 12'd2341;   // shift 16
   localparam logic [9:0]  RECIP_7    = 10'd586;    // shift 12
   localparam logic [17:0] DAYS_400Y  = 18'd146097;

   typedef struct packed {
      logic signed [25:0] y1461;
      logic signed [8:0]  cen;
      logic [8:0]         tsum;
   } s1_type;

   typedef struct packed {
      logic signed [23:0] d;
      logic [14:0]        q0;
   } s3_type;

   typedef struct packed {
      logic signed [23:0] d;
      logic [14:0]        q0;
      logic [33:0]        lim;
      logic [31:0]        d400;
   } s4_type;

   typedef struct packed {
      logic signed [23:0] d;
      logic signed [15:0] est;
   } s5_type;

   typedef struct packed {
      logic signed [15:0] iy;
      logic signed [6:0]  q;
   } cy_type;

   typedef struct packed {
      logic signed [6:0] q;
      logic [8:0]        z;
   } cz_type;

   typedef struct packed {
      logic signed [6:0] q;
      logic [8:0]        z;
      logic [10:0]       x;
   } cx_type;

   typedef struct packed {
      logic signed [6:0] q;
      logic [8:0]        z;
      logic [6:0]        f;
   } cf_type;

   typedef struct packed {
      logic signed [23:0]   d;
      logic signed [15:0]   est;
      cy_type [NCAND-1:0]   c;
   } s6_type;

   typedef struct packed {
      logic signed [23:0]   d;
      logic signed [15:0]   est;
      cz_type [NCAND-1:0]   c;
   } s7_type;

   typedef struct packed {
      logic signed [23:0]   d;
      logic signed [15:0]   est;
      cx_type [NCAND-1:0]   c;
   } s8_type;

   typedef struct packed {
      logic signed [23:0]   d;
      logic signed [15:0]   est;
      cf_type [NCAND-1:0]   c;
   } s9_type;

   typedef struct packed {
      logic signed [23:0]             d;
      logic signed [15:0]             est;
      logic signed [NCAND-1:0][23:0]  d0;
   } s10_type;

   typedef struct packed {
      logic [8:0]          diff;
      logic [WYEAR_W-1:0]  wyear;
      logic [DCOUNT_W-1:0] dcount;
   } s11_type;

   typedef struct packed {
      logic [WYEAR_W-1:0]  wyear;
      logic [WNUM_W-1:0]   wnum;
      logic [WDAY_W-1:0]   wday;
      logic [DCOUNT_W-1:0] dcount;
   } out_type;

   // floor(306 * (m + 1) / 10) for the shifted month m (3..15)
   function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
      logic [8:0] t;
      unique case (m)
         4'd3:    t = 9'd122;
         4'd4:    t = 9'd153;
         4'd5:    t = 9'd183;
         4'd6:    t = 9'd214;
         4'd7:    t = 9'd244;
         4'd8:    t = 9'd275;
         4'd9:    t = 9'd306;
         4'd10:   t = 9'd336;
         4'd11:   t = 9'd367;
         4'd12:   t = 9'd397;
         4'd13:   t = 9'd428;
         4'd14:   t = 9'd459;
         4'd15:   t = 9'd489;
         default: t = 9'd0;
      endcase
      return t;
   endfunction

endpackage

### rtl/core/gtiw_chan_if.sv
interface gtiw_req_if;
   import gtiw_pkg::*;

   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  cal_year;
   logic [MONTH_W-1:0] cal_month;
   logic [DAY_W-1:0]   cal_day;

   modport source (output valid, output cal_year, output cal_month, output cal_day,
                   input ready);
   modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                   output ready);
endinterface

interface gtiw_rsp_if;
   import gtiw_pkg::*;

   logic                valid;
   logic                ready;
   logic [WYEAR_W-1:0]  week_year;
   logic [WNUM_W-1:0]   week_number;
   logic [WDAY_W-1:0]   week_day;
   logic [DCOUNT_W-1:0] day_count;

   modport source (output valid, output week_year, output week_number, output week_day,
                   output day_count, input ready);
   modport sink   (input valid, input week_year, input week_number, input week_day,
                   input day_count, output ready);
endinterface

### rtl/core/gregorian_to_iso_week_date.sv
// channel    dir  modport  payload
// req_chan   in   sink     cal_year[13:0] cal_month[3:0] cal_day[4:0]
// rsp_chan   out  source   week_year[13:0] week_number[5:0] week_day[2:0] day_count[21:0]
//
// one date per cycle unless rsp_chan stalls while every stage is full
// each date passes through the twelve register stages of the day count and week-1 monday path
// reset clears only the stage valid bits
// a stage holds only while it and every later stage are full, so bubbles close up
// req_chan.ready is high whenever rsp_chan.ready is high
module gregorian_to_iso_week_date (
   input logic        clock,
   input logic        reset,
   gtiw_req_if.sink   req_chan,
   gtiw_rsp_if.source rsp_chan
);
   import gtiw_pkg::*;

   logic [STAGES-1:0] v_ff, v_in, en;

   s1_type             s1_ff,  s1_in;
   logic signed [23:0] s2_ff,  s2_in;
   s3_type             s3_ff,  s3_in;
   s4_type             s4_ff,  s4_in;
   s5_type             s5_ff,  s5_in;
   s6_type             s6_ff,  s6_in;
   s7_type             s7_ff,  s7_in;
   s8_type             s8_ff,  s8_in;
   s9_type             s9_ff,  s9_in;
   s10_type            s10_ff, s10_in;
   s11_type            s11_ff, s11_in;
   out_type            s12_ff, s12_in;

   // stage moves when rsp_chan is ready or it or any later stage is empty
   for (genvar g = 0; g < STAGES; g++) begin : g_en
      assign en[g] = rsp_chan.ready | ~(&v_ff[STAGES-1:g]);
   end

   assign v_in           = {v_ff[STAGES-2:0], req_chan.valid};
   assign req_chan.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // stage 1: shifted year and month, year terms, month and day sum
   always_comb begin
      logic                 early;
      logic signed [14:0]   ys;
      logic [MONTH_W-1:0]   m;
      logic [28:0]          p100;
      early = req_chan.cal_month < MONTH_MARCH;
      ys    = $signed({1'b0, req_chan.cal_year}) - (early ? 15'sd1 : 15'sd0);
      m     = early ? req_chan.cal_month + 4'd12 : req_chan.cal_month;
      p100  = 29'(ys[13:0]) * 29'(RECIP_100);
      s1_in.y1461 = 26'(ys) * 26'sd1461;
      s1_in.cen   = ys[14] ? -9'sd1 : $signed(9'(p100[28:21]));
      s1_in.tsum  = month_term(m) + 9'(req_chan.cal_day) - DAY_OFFSET;
   end

   // stage 2: day count
   always_comb begin
      s2_in = 24'(s1_ff.y1461 >>> 2) + 24'(s1_ff.cen >>> 2) - 24'(s1_ff.cen)
            + 24'(s1_ff.tsum);
   end

   // stage 3: year estimate, may be one low
   always_comb begin
      logic [38:0] p;
      p        = 39'(s2_ff[22:0]) * 39'(RECIP_YEAR);
      s3_in.d  = s2_ff;
      s3_in.q0 = p[38:24];
   end

   // stage 4: bound for the estimate correction
   always_comb begin
      s4_in.d    = s3_ff.d;
      s4_in.q0   = s3_ff.q0;
      s4_in.lim  = 34'(DAYS_400Y) * 34'({1'b0, s3_ff.q0} + 16'd1);
      s4_in.d400 = 32'(s4_in.d[22:0]) * 32'd400;
   end

   // stage 5: corrected estimate plus two, or 1 for a negative day count
   always_comb begin
      logic        ge;
      logic [14:0] q;
      ge = {2'b00, s4_ff.d400} >= s4_ff.lim;
      q  = s4_ff.q0 + 15'(ge);
      s5_in.d   = s4_ff.d;
      s5_in.est = s4_ff.d[23] ? 16'sd1 : $signed(16'(q) + 16'd2);
   end

   // stage 6: candidate years and their 400-year cycle
   always_comb begin
      logic signed [15:0] iy;
      logic [29:0]        p;
      s6_in.d   = s5_ff.d;
      s6_in.est = s5_ff.est;
      for (int k = 0; k < NCAND; k++) begin
         iy = s5_ff.est - $signed(16'(k));
         p  = 30'(iy[14:0]) * 30'(RECIP_400);
         s6_in.c[k].iy = iy;
         s6_in.c[k].q  = iy[15] ? -7'sd1 : $signed(p[29:23]);
      end
   end

   // stage 7: year within the cycle
   always_comb begin
      logic signed [15:0] zw;
      s7_in.d   = s6_ff.d;
      s7_in.est = s6_ff.est;
      for (int k = 0; k < NCAND; k++) begin
         zw = s6_ff.c[k].iy - 16'(s6_ff.c[k].q) * 16'sd400;
         s7_in.c[k].q = s6_ff.c[k].q;
         s7_in.c[k].z = zw[8:0];
      end
   end

   // stage 8: century term, floor division gives -1 at the cycle start
   always_comb begin
      logic [18:0] p;
      logic [2:0]  cz;
      s8_in.d   = s7_ff.d;
      s8_in.est = s7_ff.est;
      for (int k = 0; k < NCAND; k++) begin
         p  = 19'(s7_ff.c[k].z - 9'd1) * 19'(RECIP_100B);
         cz = p[18:16];
         s8_in.c[k].q = s7_ff.c[k].q;
         s8_in.c[k].z = s7_ff.c[k].z;
         if (s7_ff.c[k].z == 9'd0) begin
            s8_in.c[k].x = 11'd11;
         end else begin
            s8_in.c[k].x = 11'(s7_ff.c[k].z) * 11'd5 + 11'd7 - 11'({cz, 2'b00});
         end
      end
   end

   // stage 9: divide by 28
   always_comb begin
      logic [22:0] p;
      s9_in.d   = s8_ff.d;
      s9_in.est = s8_ff.est;
      for (int k = 0; k < NCAND; k++) begin
         p = 23'(s8_ff.c[k].x) * 23'(RECIP_28);
         s9_in.c[k].q = s8_ff.c[k].q;
         s9_in.c[k].z = s8_ff.c[k].z;
         s9_in.c[k].f = p[22:16];
      end
   end

   // stage 10: week-1 monday day count
   always_comb begin
      s10_in.d   = s9_ff.d;
      s10_in.est = s9_ff.est;
      for (int k = 0; k < NCAND; k++) begin
         s10_in.d0[k] = 24'(s9_ff.c[k].q) * 24'sd146097 + 24'(s9_ff.c[k].z) * 24'd364
                      + 24'(s9_ff.c[k].f) * 24'd7 + 24'd3;
      end
   end

   // stage 11: first candidate whose week 1 has started
   always_comb begin
      logic signed [23:0] d0;
      logic signed [15:0] cand;
      logic signed [23:0] diff;
      priority if (s10_ff.d >= $signed(s10_ff.d0[0])) begin
         d0   = s10_ff.d0[0];
         cand = s10_ff.est;
      end else if (s10_ff.d >= $signed(s10_ff.d0[1])) begin
         d0   = s10_ff.d0[1];
         cand = s10_ff.est - 16'sd1;
      end else if (s10_ff.d >= $signed(s10_ff.d0[2])) begin
         d0   = s10_ff.d0[2];
         cand = s10_ff.est - 16'sd2;
      end else begin
         d0   = s10_ff.d0[3];
         cand = s10_ff.est - 16'sd3;
      end
      diff = s10_ff.d - d0;
      s11_in.diff   = diff[8:0];
      s11_in.wyear  = cand[WYEAR_W-1:0];
      s11_in.dcount = s10_ff.d[DCOUNT_W-1:0];
   end

   // stage 12: week and weekday
   always_comb begin
      logic [18:0] p;
      logic [5:0]  wk;
      logic [8:0]  wd;
      p  = 19'(s11_ff.diff) * 19'(RECIP_7);
      wk = p[17:12];
      wd = s11_ff.diff - 9'(wk) * 9'd7 + 9'd1;
      s12_in.wyear  = s11_ff.wyear;
      s12_in.wnum   = wk + 6'd1;
      s12_in.wday   = wd[WDAY_W-1:0];
      s12_in.dcount = s11_ff.dcount;
   end

   always_ff @(posedge clock) begin
      if (en[0])  s1_ff  <= s1_in;
      if (en[1])  s2_ff  <= s2_in;
      if (en[2])  s3_ff  <= s3_in;
      if (en[3])  s4_ff  <= s4_in;
      if (en[4])  s5_ff  <= s5_in;
      if (en[5])  s6_ff  <= s6_in;
      if (en[6])  s7_ff  <= s7_in;
      if (en[7])  s8_ff  <= s8_in;
      if (en[8])  s9_ff  <= s9_in;
      if (en[9])  s10_ff <= s10_in;
      if (en[10]) s11_ff <= s11_in;
      if (en[11]) s12_ff <= s12_in;
   end

   assign rsp_chan.valid       = v_ff[STAGES-1];
   assign rsp_chan.week_year   = s12_ff.wyear;
   assign rsp_chan.week_number = s12_ff.wnum;
   assign rsp_chan.week_day    = s12_ff.wday;
   assign rsp_chan.day_count   = s12_ff.dcount;

endmodule

### rtl/core/gtiw_checker.sv
module gtiw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gtiw_pkg::WYEAR_W-1:0]   week_year,
   input logic [gtiw_pkg::WNUM_W-1:0]    week_number,
   input logic [gtiw_pkg::WDAY_W-1:0]    week_day,
   input logic [gtiw_pkg::DCOUNT_W-1:0]  day_count
);
   import gtiw_pkg::*;

   // weekday and week number always in their ranges
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (week_day >= 3'd1 && week_day <= 3'd7 &&
                     week_number >= 6'd1 && week_number <= 6'd53))
      else $error("week date field out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(week_year) &&
         $stable(week_number) && $stable(week_day) && $stable(day_count))
      else $error("stalled result changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a free output never holds back the input
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output ready");

   // an offered input under a ready output is taken
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_ready |-> req_ready)
      else $error("offered input not taken");

endmodule

bind gregorian_to_iso_week_date gtiw_checker u_gtiw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .week_year   (rsp_chan.week_year),
   .week_number (rsp_chan.week_number),
   .week_day    (rsp_chan.week_day),
   .day_count   (rsp_chan.day_count)
);

### tb/sv/tb_gregorian_to_iso_week_date.sv
module tb_gregorian_to_iso_week_date;
   timeunit 1ns;
   timeprecision 1ps;

   import gtiw_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   logic clock;
   logic reset;

   gtiw_req_if req_ch ();
   gtiw_rsp_if rsp_ch ();

   gregorian_to_iso_week_date DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch)
   );

   out_type pending_week_dates[$];
   int      mismatch_count = 0;
   int      send_idle_pct  = 0;
   int      stall_pct      = 0;
   int      hold_left      = 0;
   int      cycle_count    = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // floor division for a positive divisor
   function automatic longint fdiv(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   // days since 0 january of year 0, jan and feb counted as months 13 and 14
   function automatic longint day_number(input longint yr_in, input longint mo_in,
                                         input longint dy);
      longint yr, mo;
      yr = yr_in;
      mo = mo_in;
      if (mo < 3) begin
         yr = yr - 1;
         mo = mo + 12;
      end
      return fdiv(1461 * yr, 4) - fdiv(yr, 100) + fdiv(yr, 400)
           + fdiv(306 * (mo + 1), 10) + dy - 62;
   endfunction

   // day number of the monday that opens iso week 1 of year iy
   function automatic longint week_one_monday(input longint iy);
      longint q, z, wsum;
      q    = fdiv(iy, 400);
      z    = iy - 400 * q;
      wsum = 20871 * q + 52 * z + fdiv(5 * z + 7 - 4 * fdiv(z - 1, 100), 28) + 1;
      return 7 * wsum + 1 - 5;
   endfunction

   function automatic out_type predict_week_date(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m,
                                                 input logic [DAY_W-1:0] d);
      longint  dn, est, cand, mon1, diff, wk, wd;
      out_type r;
      dn   = day_number(longint'(y), longint'(m), longint'(d));
      est  = fdiv(dn * 10000, 3652425) + 2;
      cand = est;
      mon1 = week_one_monday(cand);
      for (int i = 1; i < NCAND && dn < mon1; i++) begin
         cand = est - i;
         mon1 = week_one_monday(cand);
      end
      diff     = dn - mon1;
      wk       = fdiv(diff, 7);
      wd       = diff - 7 * wk + 1;
      r.wyear  = cand[WYEAR_W-1:0];
      r.wnum   = WNUM_W'(wk + 1);
      r.wday   = WDAY_W'(wd);
      r.dcount = dn[DCOUNT_W-1:0];
      return r;
   endfunction

   function automatic int month_length(input int yr, input int mo);
      bit leap;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (mo)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // cycle limit
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_week_dates.size());
            $display("tb_gregorian_to_iso_week_date NOT OK");
            $finish;
         end
      end
   end

   // result side ready, with random stalls and long hold-offs
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_week_dates.size() == 0) begin
            flag_mismatch($sformatf("unexpected result day_count %0d", rsp_ch.day_count));
         end else begin
            want = pending_week_dates.pop_front();
            if (rsp_ch.week_year !== want.wyear)
               flag_mismatch($sformatf("week_year %0d expected %0d (day_count %0d)",
                                       rsp_ch.week_year, want.wyear, want.dcount));
            if (rsp_ch.week_number !== want.wnum)
               flag_mismatch($sformatf("week_number %0d expected %0d (day_count %0d)",
                                       rsp_ch.week_number, want.wnum, want.dcount));
            if (rsp_ch.week_day !== want.wday)
               flag_mismatch($sformatf("week_day %0d expected %0d (day_count %0d)",
                                       rsp_ch.week_day, want.wday, want.dcount));
            if (rsp_ch.day_count !== want.dcount)
               flag_mismatch($sformatf("day_count %0d expected %0d",
                                       rsp_ch.day_count, want.dcount));
         end
      end
   end

   // one date transfer, valid stays high for a following item
   task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                            input logic [DAY_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cal_year  <= y;
      req_ch.cal_month <= m;
      req_ch.cal_day   <= d;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      pending_week_dates.push_back(predict_week_date(y, m, d));
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_week_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
                            output logic [DAY_W-1:0] d);
      int kind;
      int yr, mo;
      kind = $urandom_range(99);
      if (kind < 55) begin
         yr = $urandom_range(9999, 1);
         mo = $urandom_range(12, 1);
         y  = YEAR_W'(yr);
         m  = MONTH_W'(mo);
         d  = DAY_W'($urandom_range(month_length(yr, mo), 1));
      end else if (kind < 80) begin
         // around new year, where week 1 and weeks 52/53 meet
         yr = $urandom_range(9999, 1);
         y  = YEAR_W'(yr);
         if ($urandom_range(1)) begin
            m = 4'd12;
            d = DAY_W'($urandom_range(31, 22));
         end else begin
            m = 4'd1;
            d = DAY_W'($urandom_range(10, 1));
         end
      end else if (kind < 90) begin
         yr = $urandom_range(1) ? $urandom_range(16383, 9000) : $urandom_range(3, 0);
         mo = $urandom_range(12, 1);
         y  = YEAR_W'(yr);
         m  = MONTH_W'(mo);
         d  = DAY_W'($urandom_range(month_length(yr, mo), 1));
      end else begin
         // unchecked fields across their whole width
         y = YEAR_W'($urandom);
         m = MONTH_W'($urandom);
         d = DAY_W'($urandom);
      end
   endtask

   task automatic test_calendar_corners();
      send_idle_pct = 0;
      stall_pct     <= 0;
      send_date(14'd1, 4'd1, 5'd1);
      send_date(14'd9999, 4'd12, 5'd31);
      send_date(14'd0, 4'd1, 5'd1);
      send_date(14'd0, 4'd0, 5'd0);
      send_date(14'd0, 4'd3, 5'd1);
      send_date(14'd16383, 4'd15, 5'd31);
      send_date(14'd16383, 4'd12, 5'd31);
      send_date(14'd11484, 4'd6, 5'd15);
      send_date(14'd2023, 4'd0, 5'd15);
      send_date(14'd2023, 4'd13, 5'd1);
      send_date(14'd2023, 4'd14, 5'd20);
      send_date(14'd2023, 4'd15, 5'd31);
      send_date(14'd2023, 4'd3, 5'd0);
      send_date(14'd2023, 4'd2, 5'd31);
      send_date(14'd2000, 4'd2, 5'd29);
      send_date(14'd1900, 4'd3, 5'd1);
      send_date(14'd2004, 4'd12, 5'd31);
      send_date(14'd2005, 4'd1, 5'd1);
      send_date(14'd2008, 4'd12, 5'd29);
      send_date(14'd2010, 4'd1, 5'd3);
      send_date(14'd2000, 4'd1, 5'd3);
      send_date(14'd400, 4'd1, 5'd1);
      send_date(14'd100, 4'd2, 5'd28);
      send_date(14'd401, 4'd1, 5'd1);
      wait_for_results();
   endtask

   task automatic test_random_dates(input int count, input int idle_pct, input int hold_pct);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      send_idle_pct = idle_pct;
      stall_pct     <= hold_pct;
      repeat (count) begin
         pick_date(y, m, d);
         send_date(y, m, d);
      end
      wait_for_results();
   endtask

   // receiver holds off while dates keep coming, so the pipeline fills
   task automatic test_backpressure_fill();
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      send_idle_pct = 0;
      stall_pct     <= 0;
      hold_left     <= 300;
      repeat (40) begin
         pick_date(y, m, d);
         send_date(y, m, d);
      end
      wait_for_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cal_year  = '0;
      req_ch.cal_month = '0;
      req_ch.cal_day   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_calendar_corners();
      test_random_dates(250, 0, 0);
      test_random_dates(250, 83, 0);
      test_random_dates(250, 0, 83);
      test_random_dates(250, 26, 26);
      test_backpressure_fill();

      repeat (2 * STAGES) @(posedge clock);
      if (mismatch_count == 0 && pending_week_dates.size() == 0) begin
         $display("tb_gregorian_to_iso_week_date OK");
      end else begin
         $display("tb_gregorian_to_iso_week_date NOT OK");
      end
      $finish;
   end

endmodule
